// ===== rtl/fse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the sine table generator for the Fourier series evaluator.
package fse_pkg;

    localparam int MAX_ORDER_DEF = 16;
    localparam int SINE_BITS_DEF = 10;

    localparam int ORDER_W     = 5;
    localparam int WEIGHT_W    = 18;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORDER  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT = 2'd1;

    localparam logic [ORDER_W-1:0]  ORDER_RESET  = 5'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 18'd65536;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_CLEAR,
        OP_ACCUM,
        OP_EVAL,
        OP_READ
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_INDEX,
        STAT_SATURATED
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCALE0,
        ST_SCALE1,
        ST_RUN,
        ST_DRAIN0,
        ST_DRAIN1,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [4:0]         coef_index;
        logic [15:0]        phase;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_a;
        logic signed [31:0] result_b;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic write_pair;
        logic clear_all;
        logic read_pair;
        logic scale_mult;
        logic scale_round;
        logic issue;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    bad_index;
        logic    last;
        logic    out_busy;
    } stat_t;

    // Quarter-wave sine entry in Q0.16, Taylor series in Q2.30.
    function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] r;
        int          k;
        x   = (64'(i) * HALF_PI_Q30) >> bits;
        x2  = (x * x) >> 30;
        t   = x;
        acc = x;
        for (k = 1; k <= 7; k++)
        begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) == 1)
                acc = acc - t;
            else
                acc = acc + t;
        end
        r = (acc + 64'd8192) >> 14;
        if (r > 64'd65535)
            r = 64'd65535;
        return r[15:0];
    endfunction

endpackage

// ===== rtl/fse_sine_rom.sv =====
`timescale 1ns / 1ps
// Two-port quarter-wave sine ROM with registered read data.
module fse_sine_rom #(
    parameter int SINE_TABLE_BITS = fse_pkg::SINE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [SINE_TABLE_BITS-1:0] addr_a,
    input  logic [SINE_TABLE_BITS-1:0] addr_b,
    output logic [15:0]                data_a,
    output logic [15:0]                data_b
);

    localparam int ROM_SIZE = 1 << SINE_TABLE_BITS;

    logic [15:0] rom_mem [ROM_SIZE];

    for (genvar gi = 0; gi < ROM_SIZE; gi++)
    begin : g_rom
        assign rom_mem[gi] = fse_pkg::sine_entry(gi, SINE_TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= rom_mem[addr_a];
            data_b <= rom_mem[addr_b];
        end
    end

endmodule

// ===== rtl/fse_datapath.sv =====
`timescale 1ns / 1ps
// Coefficient tables, harmonic pipeline, accumulator and result register.
module fse_datapath #(
    parameter int MAX_ORDER       = fse_pkg::MAX_ORDER_DEF,
    parameter int SINE_TABLE_BITS = fse_pkg::SINE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fse_pkg::in_item_t               in_item,
    input  logic [fse_pkg::ORDER_W-1:0]     order,
    input  logic [fse_pkg::WEIGHT_W-1:0]    weight,
    input  logic                            out_ready,
    input  fse_pkg::cmd_t                   cmd,
    output fse_pkg::stat_t                  stat,
    output logic                            out_valid,
    output fse_pkg::out_item_t              out_item
);

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (IDX_W > fse_pkg::ORDER_W) ? IDX_W : fse_pkg::ORDER_W;
    localparam int SB    = SINE_TABLE_BITS;

    // captured item
    logic [2:0]          op_reg;
    logic [4:0]          idx_reg;
    logic [15:0]         ph_reg;
    logic signed [31:0]  va_reg;
    logic signed [31:0]  vb_reg;
    logic [IDX_W-1:0]    ord_reg;
    logic [IDX_W-1:0]    ord_next;
    logic                is_accum;
    logic                is_eval;

    // harmonic sequencing
    logic [IDX_W-1:0]    n_reg;
    logic [15:0]         hp_reg;
    logic signed [50:0]  wprod_reg;
    logic signed [34:0]  ws_reg;

    // tables
    logic signed [31:0]  cos_mem [DEPTH];
    logic signed [31:0]  sin_mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic signed [31:0]  wdata_c;
    logic signed [31:0]  wdata_s;
    logic                re;
    logic [IDX_W-1:0]    raddr;

    // stage B
    logic signed [31:0]  cq_reg;
    logic signed [31:0]  sq_reg;
    logic                qv_reg;
    logic                b_valid_reg;
    logic [IDX_W-1:0]    b_n_reg;
    logic                c_one_reg;
    logic                c_neg_reg;
    logic                s_one_reg;
    logic                s_neg_reg;
    logic [SB+1:0]       c_look;
    logic [SB+1:0]       s_look;
    logic [15:0]         rom_c;
    logic [15:0]         rom_s;
    logic signed [31:0]  cq_m;
    logic signed [31:0]  sq_m;
    logic signed [17:0]  c_val;
    logic signed [17:0]  s_val;
    logic signed [34:0]  mul_c;
    logic signed [34:0]  mul_s;

    // stage C
    logic                c_valid_reg;
    logic [IDX_W-1:0]    c_n_reg;
    logic signed [52:0]  pc_reg;
    logic signed [52:0]  ps_reg;
    logic signed [31:0]  oldc_reg;
    logic signed [31:0]  olds_reg;
    logic signed [36:0]  rc;
    logic signed [36:0]  rs;
    logic [32:0]         satc;
    logic [32:0]         sats;
    logic signed [52:0]  term_c;
    logic signed [57:0]  acc_reg;
    logic                hit_reg;

    // result
    logic [32:0]         satf;
    logic                out_valid_reg;
    fse_pkg::out_item_t  out_reg;

    function automatic logic [SB+1:0] rom_lookup(input logic [15:0] p);
        logic [SB-1:0] k;
        logic [SB-1:0] a;
        logic          one;
        k   = p[13 -: SB];
        a   = p[14] ? (~k + 1'b1) : k;
        one = p[14] && (k == '0);
        return {p[15], one, a};
    endfunction

    // {hit, value}
    function automatic logic [32:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < -42'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    assign is_accum = (op_reg == fse_pkg::OP_ACCUM);
    assign is_eval  = (op_reg == fse_pkg::OP_EVAL);

    always_comb
    begin
        if (order == '0)
            ord_next = IDX_W'(1);
        else if (CMP_W'(order) > CMP_W'(MAX_ORDER))
            ord_next = IDX_W'(MAX_ORDER);
        else
            ord_next = IDX_W'(order);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_item.opcode;
            idx_reg <= in_item.coef_index;
            ph_reg  <= in_item.phase;
            va_reg  <= in_item.value_a;
            vb_reg  <= in_item.value_b;
            ord_reg <= ord_next;
        end
        if (cmd.scale_mult)
            wprod_reg <= va_reg * $signed({1'b0, weight});
        if (cmd.scale_round)
            ws_reg <= 35'((wprod_reg + 51'sd32768) >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg  <= '0;
            hp_reg <= '0;
        end
        else if (cmd.issue)
        begin
            n_reg  <= n_reg + 1'b1;
            hp_reg <= hp_reg + ph_reg;
        end
    end

    assign stat.opcode    = fse_pkg::opcode_t'(op_reg);
    assign stat.bad_index = ((op_reg == fse_pkg::OP_WRITE) || (op_reg == fse_pkg::OP_READ))
                            && (CMP_W'(idx_reg) > CMP_W'(ord_reg));
    assign stat.last      = (n_reg == ord_reg);
    assign stat.out_busy  = out_valid_reg;

    // table ports
    assign we      = cmd.write_pair || (c_valid_reg && is_accum);
    assign waddr   = cmd.write_pair ? IDX_W'(idx_reg) : c_n_reg;
    assign wdata_c = cmd.write_pair ? va_reg : satc[31:0];
    assign wdata_s = cmd.write_pair ? vb_reg : sats[31:0];
    assign re      = cmd.issue || cmd.read_pair;
    assign raddr   = cmd.issue ? n_reg : IDX_W'(idx_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cos_mem[waddr] <= wdata_c;
            sin_mem[waddr] <= wdata_s;
        end
        if (re)
        begin
            cq_reg <= cos_mem[raddr];
            sq_reg <= sin_mem[raddr];
            qv_reg <= vld_reg[raddr];
        end
    end

    // entries never written since reset or clear read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.clear_all)
            vld_reg <= '0;
        else if (we)
            vld_reg[waddr] <= 1'b1;
    end

    assign c_look = rom_lookup(hp_reg + 16'h4000);
    assign s_look = rom_lookup(hp_reg);

    fse_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (cmd.issue),
        .addr_a (c_look[SB-1:0]),
        .addr_b (s_look[SB-1:0]),
        .data_a (rom_c),
        .data_b (rom_s)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            b_n_reg   <= n_reg;
            c_neg_reg <= c_look[SB+1];
            c_one_reg <= c_look[SB];
            s_neg_reg <= s_look[SB+1];
            s_one_reg <= s_look[SB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= cmd.issue;
            c_valid_reg <= b_valid_reg;
        end
    end

    // stage B: signed Q1.16 sine values and the two products
    always_comb
    begin
        cq_m  = qv_reg ? cq_reg : 32'sd0;
        sq_m  = qv_reg ? sq_reg : 32'sd0;
        c_val = c_one_reg ? 18'sd65536 : $signed({2'b00, rom_c});
        s_val = s_one_reg ? 18'sd65536 : $signed({2'b00, rom_s});
        if (c_neg_reg)
            c_val = -c_val;
        if (s_neg_reg)
            s_val = -s_val;
        mul_c = is_accum ? ws_reg : 35'(cq_m);
        mul_s = is_accum ? ws_reg : 35'(sq_m);
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            c_n_reg  <= b_n_reg;
            pc_reg   <= mul_c * c_val;
            ps_reg   <= mul_s * s_val;
            oldc_reg <= cq_m;
            olds_reg <= sq_m;
        end
    end

    // stage C: write back or sum
    always_comb
    begin
        rc     = 37'((pc_reg + 53'sd32768) >>> 16);
        rs     = 37'((ps_reg + 53'sd32768) >>> 16);
        satc   = sat32(42'(oldc_reg) + 42'(rc));
        sats   = sat32(42'(olds_reg) + 42'(rs));
        // constant term enters at half weight; cos(0) is exactly one
        term_c = (c_n_reg == '0) ? (pc_reg >>> 1) : pc_reg;
        satf   = sat32(42'((acc_reg + 58'sd32768) >>> 16));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            acc_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (c_valid_reg)
        begin
            if (is_eval)
                acc_reg <= acc_reg + 58'(term_c) + 58'(ps_reg);
            if (is_accum && (satc[32] || sats[32]))
                hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_reg.result_a <= '0;
            out_reg.result_b <= '0;
            out_reg.status   <= fse_pkg::STAT_OK;
            if (stat.bad_index)
                out_reg.status <= fse_pkg::STAT_BAD_INDEX;
            else if (op_reg == fse_pkg::OP_READ)
            begin
                out_reg.result_a <= cq_m;
                out_reg.result_b <= sq_m;
            end
            else if (is_eval)
            begin
                out_reg.result_a <= satf[31:0];
                if (satf[32])
                    out_reg.status <= fse_pkg::STAT_SATURATED;
            end
            else if (is_accum && hit_reg)
                out_reg.status <= fse_pkg::STAT_SATURATED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/fse_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps the datapath through one item at a time.
module fse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic           out_ready,
    input  fse_pkg::stat_t stat,
    output fse_pkg::cmd_t  cmd
);

    fse_pkg::state_t state_reg;
    fse_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fse_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fse_pkg::ST_IDLE:
                if (in_valid)
                    state_next = fse_pkg::ST_DECODE;
            fse_pkg::ST_DECODE:
                if (stat.bad_index)
                    state_next = fse_pkg::ST_DONE;
                else
                begin
                    unique case (stat.opcode)
                        fse_pkg::OP_ACCUM: state_next = fse_pkg::ST_SCALE0;
                        fse_pkg::OP_EVAL:  state_next = fse_pkg::ST_RUN;
                        default:           state_next = fse_pkg::ST_DONE;
                    endcase
                end
            fse_pkg::ST_SCALE0: state_next = fse_pkg::ST_SCALE1;
            fse_pkg::ST_SCALE1: state_next = fse_pkg::ST_RUN;
            fse_pkg::ST_RUN:
                if (stat.last)
                    state_next = fse_pkg::ST_DRAIN0;
            fse_pkg::ST_DRAIN0: state_next = fse_pkg::ST_DRAIN1;
            fse_pkg::ST_DRAIN1: state_next = fse_pkg::ST_DONE;
            fse_pkg::ST_DONE:
                if (!stat.out_busy || out_ready)
                    state_next = fse_pkg::ST_IDLE;
            default: state_next = fse_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            fse_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            fse_pkg::ST_DECODE:
                if (!stat.bad_index)
                begin
                    unique case (stat.opcode)
                        fse_pkg::OP_WRITE: cmd.write_pair = 1'b1;
                        fse_pkg::OP_CLEAR: cmd.clear_all  = 1'b1;
                        fse_pkg::OP_READ:  cmd.read_pair  = 1'b1;
                        default:           cmd.write_pair = 1'b0;
                    endcase
                end
            fse_pkg::ST_SCALE0: cmd.scale_mult  = 1'b1;
            fse_pkg::ST_SCALE1: cmd.scale_round = 1'b1;
            fse_pkg::ST_RUN:    cmd.issue       = 1'b1;
            fse_pkg::ST_DONE:   cmd.load_result = !stat.out_busy || out_ready;
            default:            cmd             = '0;
        endcase
    end

endmodule

// ===== rtl/fourier_series_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the truncated Fourier series evaluator.
//
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  in_data   (fse_pkg::in_item_t)
// out       output     out_valid/out_ready  out_data  (fse_pkg::out_item_t)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// One item is in flight at a time. Write, clear, read, a bad index or an
// unknown opcode go from decode straight to the result load. Evaluate runs
// harmonics 0 to order through the harmonic loop; accumulate first scales
// its value by the weight and then does the same. The harmonic loop issues
// one harmonic per cycle into a three-stage table/ROM/multiply pipeline
// with one multiplier pair, which drains before the result load.
// Reset sets order 1 and weight 1.0 and empties the tables at once (per-entry
// valid flags); no clearing pass is needed. A result waiting on out_ready
// does not block the next input transfer; only the load of the following
// result waits for the output register to drain.
module fourier_series_evaluator #(
    parameter int MAX_ORDER       = fse_pkg::MAX_ORDER_DEF,
    parameter int SINE_TABLE_BITS = fse_pkg::SINE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fse_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fse_pkg::WEIGHT_W-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  fse_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output fse_pkg::out_item_t                 out_data
);

    logic [fse_pkg::ORDER_W-1:0]  order_reg;
    logic [fse_pkg::WEIGHT_W-1:0] weight_reg;
    fse_pkg::cmd_t                cmd;
    fse_pkg::stat_t               stat;

    // Configuration registers; writes to other indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= fse_pkg::ORDER_RESET;
            weight_reg <= fse_pkg::WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == fse_pkg::CFG_ORDER)
                order_reg <= cfg_data[fse_pkg::ORDER_W-1:0];
            else if (cfg_index == fse_pkg::CFG_WEIGHT)
                weight_reg <= cfg_data;
        end
    end

    // Sequencer: owns in_ready and steps the datapath.
    fse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: tables, sine ROM, multiplier pair, accumulator, output register.
    fse_datapath #(
        .MAX_ORDER       (MAX_ORDER),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .order     (order_reg),
        .weight    (weight_reg),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_item  (out_data)
    );

    // One item at a time: a transfer closes the input until the result is loaded.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("undefined status code");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == fse_pkg::STAT_BAD_INDEX
        |-> out_data.result_a == 32'sd0 && out_data.result_b == 32'sd0)
        else $error("bad index result carries data");

endmodule

// ===== tb/fse_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Fourier series evaluator: predicts every result and compares it.
module fse_checker
    import fse_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WEIGHT_W-1:0]    cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  out_item_t              out_data,
    output int                     fail_count,
    output int                     pending
);

    localparam int HARMONICS = MAX_ORDER_DEF + 1;
    localparam int ROM_DEPTH = 1 << SINE_BITS_DEF;

    logic signed [31:0] cos_tab [HARMONICS];
    logic signed [31:0] sin_tab [HARMONICS];
    logic [15:0]        sine_rom [ROM_DEPTH];
    logic [ORDER_W-1:0] order_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    out_item_t          expected_q [$];

    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned total;
        longint unsigned r;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            x     = (longint'(i) * HALF_PI_Q30) >> SINE_BITS_DEF;
            x2    = (x * x) >> 30;
            term  = x;
            total = x;
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    total = total - term;
                else
                    total = total + term;
            end
            r = (total + 8192) >> 14;
            sine_rom[i] = (r > 65535) ? 16'hFFFF : r[15:0];
        end
    end

    function automatic longint sine_at(logic [15:0] p);
        logic [9:0] k;
        longint     v;
        k = p[13:4];
        if (p[14])
            v = (k == 0) ? 65536 : longint'(sine_rom[ROM_DEPTH - int'(k)]);
        else
            v = longint'(sine_rom[k]);
        return p[15] ? -v : v;
    endfunction

    function automatic longint round_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v, inout bit hit);
        if (v > 64'sd2147483647)
        begin
            hit = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -64'sd2147483648)
        begin
            hit = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Apply one item to the shadow tables and return the result it yields.
    function automatic out_item_t apply_item(in_item_t it);
        out_item_t   res;
        int          ord;
        bit          hit;
        longint      ws;
        longint      acc;
        logic [15:0] hp;
        res = '0;
        hit = 1'b0;
        ord = (order_reg < 1) ? 1 : (order_reg > MAX_ORDER_DEF) ? MAX_ORDER_DEF : order_reg;
        if (it.opcode == OP_WRITE || it.opcode == OP_READ)
        begin
            if (it.coef_index > ord)
                res.status = STAT_BAD_INDEX;
            else if (it.opcode == OP_WRITE)
            begin
                cos_tab[it.coef_index] = it.value_a;
                sin_tab[it.coef_index] = it.value_b;
            end
            else
            begin
                res.result_a = cos_tab[it.coef_index];
                res.result_b = sin_tab[it.coef_index];
            end
        end
        else if (it.opcode == OP_CLEAR)
        begin
            for (int n = 0; n < HARMONICS; n++)
            begin
                cos_tab[n] = '0;
                sin_tab[n] = '0;
            end
        end
        else if (it.opcode == OP_ACCUM)
        begin
            ws = round_q16(longint'(it.value_a) * longint'(weight_reg));
            for (int n = 0; n <= ord; n++)
            begin
                hp = 16'(n * it.phase);
                cos_tab[n] = clamp32(longint'(cos_tab[n])
                                     + round_q16(ws * sine_at(hp + 16'h4000)), hit);
                sin_tab[n] = clamp32(longint'(sin_tab[n])
                                     + round_q16(ws * sine_at(hp)), hit);
            end
            if (hit)
                res.status = STAT_SATURATED;
        end
        else if (it.opcode == OP_EVAL)
        begin
            acc = longint'(cos_tab[0]) * 32768;
            for (int n = 1; n <= ord; n++)
            begin
                hp  = 16'(n * it.phase);
                acc += longint'(cos_tab[n]) * sine_at(hp + 16'h4000)
                       + longint'(sin_tab[n]) * sine_at(hp);
            end
            res.result_a = clamp32(round_q16(acc), hit);
            if (hit)
                res.status = STAT_SATURATED;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int n = 0; n < HARMONICS; n++)
            begin
                cos_tab[n] = '0;
                sin_tab[n] = '0;
            end
            order_reg  = ORDER_RESET;
            weight_reg = WEIGHT_RESET;
            expected_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == CFG_ORDER)
                    order_reg = cfg_data[ORDER_W-1:0];
                else if (cfg_index == CFG_WEIGHT)
                    weight_reg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t unexpected result a=%h b=%h st=%0d", $realtime,
                                 out_data.result_a, out_data.result_b, out_data.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want !== out_data)
                    begin
                        if (fail_count < 10)
                            $display("%0t mismatch exp a=%h b=%h st=%0d got a=%h b=%h st=%0d",
                                     $realtime, want.result_a, want.result_b, want.status,
                                     out_data.result_a, out_data.result_b, out_data.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(apply_item(in_data));
            pending <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict for the Fourier series evaluator.
module tb_top;
    import fse_pkg::*;

    // Opcodes outside the defined set must be ignored by the block.
    localparam logic [2:0] OP_BOGUS_FIRST = 3'd5;
    localparam logic [2:0] OP_BOGUS_MID   = 3'd6;
    localparam logic [2:0] OP_BOGUS_LAST  = 3'd7;
    localparam int         CYCLE_LIMIT    = 600000;
    localparam int         PHASES         = 7;
    localparam int         PER_PHASE      = 160;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WEIGHT_W-1:0]    cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;
    int                     fail_count;
    int                     pending;
    int                     cycles = 0;
    int                     stall_left = 0;
    int                     live_order = 1;
    bit                     calm = 1'b0;

    always #5 clk = ~clk;

    fourier_series_evaluator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    fse_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[fourier_series_evaluator] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: random stall bursts, none when calm.
    always @(posedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one item; unless calm, sometimes drop valid for a random gap first.
    task automatic send_item(in_item_t it);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_op(logic [2:0] op, int idx, int ph, int va, int vb);
        in_item_t it;
        it.opcode     = op;
        it.coef_index = 5'(idx);
        it.phase      = 16'(ph);
        it.value_a    = va;
        it.value_b    = vb;
        send_item(it);
    endtask

    // Hold until every expected result has been transferred.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= WEIGHT_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            2: return int'($urandom_range(0, 1 << 24)) - (1 << 23);
            default: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    // Random item: mostly well-formed table traffic, a little noise.
    function automatic in_item_t random_item();
        in_item_t it;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            it.opcode = OP_WRITE;
        else if (roll < 45)
            it.opcode = OP_ACCUM;
        else if (roll < 70)
            it.opcode = OP_EVAL;
        else if (roll < 93)
            it.opcode = OP_READ;
        else if (roll < 97)
            it.opcode = OP_CLEAR;
        else
            it.opcode = 3'($urandom_range(OP_BOGUS_FIRST, OP_BOGUS_LAST));
        if ($urandom_range(0, 9) < 8)
            it.coef_index = 5'($urandom_range(0, live_order + 1));
        else
            it.coef_index = 5'($urandom_range(0, 31));
        it.phase   = 16'($urandom);
        it.value_a = pick_value();
        it.value_b = pick_value();
        return it;
    endfunction

    initial
    begin
        int orders  [PHASES] = '{16, 0, 31, 7, 3, 12, 1};
        int weights [PHASES] = '{131072, 0, 262143, 1000, 32768, 65536, 65536};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, index limits, quadrant phases, saturation, noise.
        send_op(OP_READ, 0, 0, 0, 0);
        send_op(OP_WRITE, 0, 0, 32'sh7FFFFFFF, 32'sh80000000);
        send_op(OP_WRITE, 1, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_op(OP_WRITE, 2, 0, 5, 6);
        send_op(OP_READ, 2, 0, 0, 0);
        send_op(OP_READ, 31, 16'hFFFF, -1, -1);
        send_op(OP_READ, 0, 0, 0, 0);
        send_op(OP_EVAL, 0, 16'h0000, 0, 0);
        send_op(OP_EVAL, 0, 16'h2000, 0, 0);
        send_op(OP_EVAL, 0, 16'h4000, 0, 0);
        send_op(OP_EVAL, 0, 16'h8000, 0, 0);
        send_op(OP_EVAL, 0, 16'hC000, 0, 0);
        send_op(OP_EVAL, 0, 16'hFFFF, 0, 0);
        send_op(OP_ACCUM, 0, 16'h1000, 32'sh7FFFFFFF, 0);
        send_op(OP_READ, 1, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0);
        send_op(OP_ACCUM, 0, 16'h4000, 32'sh80000000, 0);
        send_op(OP_ACCUM, 0, 16'h0010, 32'sh00010000, 0);
        send_op(OP_READ, 0, 0, 0, 0);
        send_op(OP_READ, 1, 0, 0, 0);
        send_op(OP_BOGUS_FIRST, 1, 0, -1, -1);
        send_op(OP_BOGUS_LAST, 31, 16'hFFFF, -1, -1);
        send_op(OP_BOGUS_MID, 0, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0);

        // Random phases, one register setting each; the last one runs calm.
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            write_reg(CFG_ORDER, orders[p]);
            write_reg(CFG_WEIGHT, weights[p]);
            live_order = (orders[p] < 1) ? 1 : (orders[p] > MAX_ORDER_DEF) ? MAX_ORDER_DEF
                                                                             : orders[p];
            calm = (p == PHASES - 1);
            for (int i = 0; i < PER_PHASE; i++)
                send_item(random_item());
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[fourier_series_evaluator] OK");
        else
            $display("[fourier_series_evaluator] ERROR");
        $finish;
    end

endmodule
